// ----- rtl/att_pkg.sv -----
// Shared types, constants and register map for the adaptive transfer tuner.
`default_nettype none

package att_pkg;

  // Throughput fraction bits, default
  localparam int RATE_FRAC_BITS_DEF = 16;

  // Configuration port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  localparam int CHUNK_W = 32;
  localparam int DEPTH_W = 16;
  localparam int ELAPSED_W = 48;
  localparam int RATE_W = 48;

  // Register reset values
  localparam logic [CHUNK_W-1:0] MIN_CHUNK_RST   = 32'd4096;
  localparam logic [CHUNK_W-1:0] MAX_CHUNK_RST   = 32'd1048576;
  localparam logic [DEPTH_W-1:0] MIN_DEPTH_RST   = 16'd1;
  localparam logic [DEPTH_W-1:0] MAX_DEPTH_RST   = 16'd64;
  localparam logic [CHUNK_W-1:0] START_CHUNK_RST = 32'd65536;
  localparam logic [DEPTH_W-1:0] START_DEPTH_RST = 16'd4;

  // Reset start values already lie inside the reset bounds
  localparam logic [CHUNK_W-1:0] CHUNK_NOW_RST = START_CHUNK_RST;
  localparam logic [DEPTH_W-1:0] DEPTH_NOW_RST = START_DEPTH_RST;

  typedef enum logic [2:0] {
    REG_MIN_CHUNK   = 3'd0,
    REG_MAX_CHUNK   = 3'd1,
    REG_MIN_DEPTH   = 3'd2,
    REG_MAX_DEPTH   = 3'd3,
    REG_START_CHUNK = 3'd4,
    REG_START_DEPTH = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_NONPOS     = 2'd2,
    ST_BAD_BOUNDS = 2'd3
  } status_t;

  localparam logic OP_OBSERVE = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef struct packed {
    logic                        op;
    logic [CHUNK_W-1:0]          bytes_done;
    logic signed [ELAPSED_W-1:0] elapsed_ns;
    logic                        link_error;
    logic                        mem_pressure;
    logic                        starved;
  } sample_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [CHUNK_W-1:0] chunk_out;
    logic [DEPTH_W-1:0] depth_out;
  } result_t;

  typedef struct packed {
    logic [CHUNK_W-1:0] min_chunk;
    logic [CHUNK_W-1:0] max_chunk;
    logic [DEPTH_W-1:0] min_depth;
    logic [DEPTH_W-1:0] max_depth;
    logic [CHUNK_W-1:0] start_chunk;
    logic [DEPTH_W-1:0] start_depth;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_SAT,
    S_MUL,
    S_CMP,
    S_APPLY,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;      // capture the incoming word
    logic div_load;  // set up the divider
    logic div_step;  // one quotient bit
    logic sat;       // register the saturated measurement
    logic mul;       // register the threshold products
    logic cmp;       // register the gain and drop flags
    logic apply;     // update the tuner state
    logic emit;      // load the result register
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/att_regs.sv -----
// APB configuration registers of the adaptive transfer tuner.
`default_nettype none

module att_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [att_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [att_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [att_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                  pready,
  output att_pkg::cfg_t                         cfg
);

  att_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx    = att_pkg::reg_idx_t'(paddr[att_pkg::APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_chunk   <= att_pkg::MIN_CHUNK_RST;
      cfg.max_chunk   <= att_pkg::MAX_CHUNK_RST;
      cfg.min_depth   <= att_pkg::MIN_DEPTH_RST;
      cfg.max_depth   <= att_pkg::MAX_DEPTH_RST;
      cfg.start_chunk <= att_pkg::START_CHUNK_RST;
      cfg.start_depth <= att_pkg::START_DEPTH_RST;
    end else if (wr_en) begin
      case (idx)
        att_pkg::REG_MIN_CHUNK:   cfg.min_chunk   <= pwdata[att_pkg::CHUNK_W-1:0];
        att_pkg::REG_MAX_CHUNK:   cfg.max_chunk   <= pwdata[att_pkg::CHUNK_W-1:0];
        att_pkg::REG_MIN_DEPTH:   cfg.min_depth   <= pwdata[att_pkg::DEPTH_W-1:0];
        att_pkg::REG_MAX_DEPTH:   cfg.max_depth   <= pwdata[att_pkg::DEPTH_W-1:0];
        att_pkg::REG_START_CHUNK: cfg.start_chunk <= pwdata[att_pkg::CHUNK_W-1:0];
        att_pkg::REG_START_DEPTH: cfg.start_depth <= pwdata[att_pkg::DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      att_pkg::REG_MIN_CHUNK:   prdata = att_pkg::APB_DATA_W'(cfg.min_chunk);
      att_pkg::REG_MAX_CHUNK:   prdata = att_pkg::APB_DATA_W'(cfg.max_chunk);
      att_pkg::REG_MIN_DEPTH:   prdata = att_pkg::APB_DATA_W'(cfg.min_depth);
      att_pkg::REG_MAX_DEPTH:   prdata = att_pkg::APB_DATA_W'(cfg.max_depth);
      att_pkg::REG_START_CHUNK: prdata = att_pkg::APB_DATA_W'(cfg.start_chunk);
      att_pkg::REG_START_DEPTH: prdata = att_pkg::APB_DATA_W'(cfg.start_depth);
      default:                  prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/att_ctrl.sv -----
// Sequencing state machine of the adaptive transfer tuner.
`default_nettype none

module att_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              sample_valid,
  output logic                   sample_ready,
  input  wire att_pkg::dp_stat_t stat,
  output att_pkg::cmd_t          cmd
);

  att_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= att_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    sample_ready = 1'b0;
    case (state)
      att_pkg::S_IDLE: begin
        sample_ready = 1'b1;
        if (sample_valid) begin
          cmd.load   = 1'b1;
          state_next = att_pkg::S_CHECK;
        end
      end
      att_pkg::S_CHECK: begin
        // only a valid observe word with a usable interval needs the quotient
        if (stat.need_div) begin
          cmd.div_load = 1'b1;
          state_next   = att_pkg::S_DIV;
        end else begin
          state_next = att_pkg::S_APPLY;
        end
      end
      att_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_next = att_pkg::S_SAT;
        end
      end
      att_pkg::S_SAT: begin
        cmd.sat    = 1'b1;
        state_next = att_pkg::S_MUL;
      end
      att_pkg::S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = att_pkg::S_CMP;
      end
      att_pkg::S_CMP: begin
        cmd.cmp    = 1'b1;
        state_next = att_pkg::S_APPLY;
      end
      att_pkg::S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = att_pkg::S_EMIT;
      end
      att_pkg::S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = att_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = att_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/att_dp.sv -----
// Datapath of the adaptive transfer tuner: serial divider, thresholds and state update.
`default_nettype none

module att_dp #(
  parameter int RATE_FRAC_BITS = att_pkg::RATE_FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire att_pkg::cmd_t     cmd,
  output att_pkg::dp_stat_t      stat,
  input  wire att_pkg::cfg_t     cfg,
  input  wire att_pkg::sample_t  sample,
  output att_pkg::result_t       result,
  output logic                   result_valid,
  input  wire logic              result_ready
);

  localparam int CW  = att_pkg::CHUNK_W;
  localparam int DPW = att_pkg::DEPTH_W;
  localparam int RW  = att_pkg::RATE_W;
  localparam int EW  = att_pkg::ELAPSED_W;
  localparam int DW  = CW + RATE_FRAC_BITS;   // dividend and quotient width
  localparam int NW  = EW - 1;                // positive divisor magnitude
  localparam int CNW = $clog2(DW);
  localparam int PW  = RW + 7;                // products by constants below 128
  localparam int SW  = RW + 2;                // 3*avg + meas

  att_pkg::sample_t smp;

  // tuner state
  logic [CW-1:0]  chunk_now;
  logic [DPW-1:0] depth_now;
  logic [RW-1:0]  rate_avg;
  logic           gain_streak;

  logic [CW-1:0]  chunk_next;
  logic [DPW-1:0] depth_next;
  logic [RW-1:0]  avg_next;
  logic           streak_next;
  logic [1:0]     status_next;
  logic [1:0]     status_q;

  // divider
  logic [DW-1:0]  dvd;        // dividend bits out, quotient bits in
  logic [NW-1:0]  dvsr;
  logic [NW-1:0]  rem;
  logic [CNW-1:0] cnt;
  logic [NW:0]    rem_sh;
  logic [NW:0]    rem_diff;
  logic           q_bit;

  logic [DW+RW-1:0] quot_x;
  logic [RW-1:0]    meas;
  logic [PW-1:0]    p_m100, p_a103, p_m40, p_a37;
  logic             gain, drop;

  logic bounds_ok, el_pos, is_empty, is_nonpos;
  logic [SW-1:0] avg_sum;

  // ---------------------------------------------------------------- helpers
  function automatic logic [DPW-1:0] shrink_depth(input logic [DPW-1:0] d,
                                                  input logic [DPW-1:0] lo);
    logic [DPW-1:0] h;
    h = d >> 1;
    return (h > lo) ? h : lo;
  endfunction

  function automatic logic [CW-1:0] shrink_chunk(input logic [CW-1:0] c,
                                                 input logic [CW-1:0] lo);
    logic [CW-1:0] h;
    h = c >> 1;
    return (h > lo) ? h : lo;
  endfunction

  function automatic logic [DPW-1:0] grow_depth(input logic [DPW-1:0] d,
                                                input logic [DPW-1:0] hi);
    logic [DPW-1:0] inc;
    inc = d >> 2;
    if (inc == '0) inc = DPW'(1);
    if (d >= hi || inc > (hi - d)) return hi;
    return d + inc;
  endfunction

  function automatic logic [CW-1:0] double_chunk(input logic [CW-1:0] c,
                                                 input logic [CW-1:0] hi);
    if (c >= hi || c > (hi - c)) return hi;
    return c + c;
  endfunction

  // ---------------------------------------------------------- classification
  assign bounds_ok = (cfg.min_chunk != '0) && (cfg.min_depth != '0) &&
                     (cfg.min_chunk <= cfg.max_chunk) && (cfg.min_depth <= cfg.max_depth);
  assign el_pos    = (smp.elapsed_ns != '0) && !smp.elapsed_ns[EW-1];
  assign is_empty  = (smp.bytes_done == '0) && !smp.link_error;
  assign is_nonpos = !el_pos && !smp.link_error;

  assign stat.need_div = bounds_ok && (smp.op == att_pkg::OP_OBSERVE) && !is_empty &&
                         !is_nonpos && !smp.link_error;
  assign stat.div_done = (cnt == CNW'(DW - 1));
  assign stat.out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp <= sample;
    end
  end

  // ------------------------------------------------- restoring serial divider
  assign rem_sh   = {rem, dvd[DW-1]};
  assign rem_diff = rem_sh - {1'b0, dvsr};
  assign q_bit    = (rem_sh >= {1'b0, dvsr});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dvd  <= DW'(smp.bytes_done) << RATE_FRAC_BITS;
      dvsr <= smp.elapsed_ns[NW-1:0];
      rem  <= '0;
      cnt  <= '0;
    end else if (cmd.div_step) begin
      dvd  <= {dvd[DW-2:0], q_bit};
      rem  <= q_bit ? rem_diff[NW-1:0] : rem_sh[NW-1:0];
      cnt  <= cnt + CNW'(1);
    end
  end

  // saturate the quotient to the rate width
  assign quot_x = {{RW{1'b0}}, dvd};

  always_ff @(posedge clk) begin
    if (cmd.sat) begin
      meas <= (|quot_x[DW+RW-1:RW]) ? {RW{1'b1}} : quot_x[RW-1:0];
    end
  end

  // rise of 3 % : 100*meas >= 103*avg, fall of 7.5 % : 40*meas <= 37*avg
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      p_m100 <= (PW'(meas) << 6) + (PW'(meas) << 5) + (PW'(meas) << 2);
      p_a103 <= (PW'(rate_avg) << 6) + (PW'(rate_avg) << 5) + (PW'(rate_avg) << 2) +
                (PW'(rate_avg) << 1) + PW'(rate_avg);
      p_m40  <= (PW'(meas) << 5) + (PW'(meas) << 3);
      p_a37  <= (PW'(rate_avg) << 5) + (PW'(rate_avg) << 2) + PW'(rate_avg);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      gain <= (p_m100 >= p_a103);
      drop <= (p_m40 <= p_a37);
    end
  end

  // ------------------------------------------------------------ state update
  assign avg_sum = SW'(rate_avg) + (SW'(rate_avg) << 1) + SW'(meas);

  always_comb begin
    chunk_next  = chunk_now;
    depth_next  = depth_now;
    avg_next    = rate_avg;
    streak_next = gain_streak;
    status_next = att_pkg::ST_OK;
    if (!bounds_ok) begin
      status_next = att_pkg::ST_BAD_BOUNDS;
    end else if (smp.op == att_pkg::OP_RESTART) begin
      chunk_next  = (cfg.start_chunk < cfg.min_chunk) ? cfg.min_chunk :
                    (cfg.start_chunk > cfg.max_chunk) ? cfg.max_chunk : cfg.start_chunk;
      depth_next  = (cfg.start_depth < cfg.min_depth) ? cfg.min_depth :
                    (cfg.start_depth > cfg.max_depth) ? cfg.max_depth : cfg.start_depth;
      avg_next    = '0;
      streak_next = 1'b0;
    end else if (is_empty) begin
      status_next = att_pkg::ST_EMPTY;
    end else if (is_nonpos) begin
      status_next = att_pkg::ST_NONPOS;
    end else if (smp.link_error) begin
      depth_next  = shrink_depth(depth_now, cfg.min_depth);
      chunk_next  = shrink_chunk(chunk_now, cfg.min_chunk);
      avg_next    = '0;
      streak_next = 1'b0;
    end else if (smp.mem_pressure) begin
      // chunk only gives way once depth is already at its floor
      depth_next  = shrink_depth(depth_now, cfg.min_depth);
      if (depth_now == cfg.min_depth) begin
        chunk_next = shrink_chunk(chunk_now, cfg.min_chunk);
      end
      avg_next    = meas;
      streak_next = 1'b0;
    end else if (rate_avg == '0) begin
      avg_next = meas;
    end else begin
      if (gain) begin
        depth_next = grow_depth(depth_now, cfg.max_depth);
        if (gain_streak) begin
          chunk_next  = double_chunk(chunk_now, cfg.max_chunk);
          streak_next = 1'b0;
        end else begin
          streak_next = 1'b1;
        end
      end else if (drop) begin
        depth_next  = shrink_depth(depth_now, cfg.min_depth);
        chunk_next  = shrink_chunk(chunk_now, cfg.min_chunk);
        streak_next = 1'b0;
      end else if (smp.starved) begin
        depth_next  = grow_depth(depth_now, cfg.max_depth);
        streak_next = 1'b0;
      end else begin
        streak_next = 1'b0;
      end
      avg_next = avg_sum[SW-1:2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_now   <= att_pkg::CHUNK_NOW_RST;
      depth_now   <= att_pkg::DEPTH_NOW_RST;
      rate_avg    <= '0;
      gain_streak <= 1'b0;
    end else if (cmd.apply) begin
      chunk_now   <= chunk_next;
      depth_now   <= depth_next;
      rate_avg    <= avg_next;
      gain_streak <= streak_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      status_q <= status_next;
    end
  end

  // -------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.status    <= status_q;
      result.chunk_out <= chunk_now;
      result.depth_out <= depth_now;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/adaptive_transfer_tuner.sv -----
// Top level of the adaptive transfer tuner.
`default_nettype none

// Takes one transfer sample word at a time and returns one result word with a status and
// the current chunk size and pipeline depth. Throughput is (bytes_done << RATE_FRAC_BITS)
// divided by elapsed_ns in a restoring divider that produces one quotient bit per cycle.
// An observe word with a usable interval passes through the check, divide, saturate,
// multiply, compare, apply and emit states; restart, error, empty, non-positive and
// bad-bounds words skip the divider and go from check straight to apply and emit. A new
// word is accepted only once the previous one has reached the result register, which
// may still be waiting to be taken. Configuration is written through the APB port while
// the block is idle; a write does not re-clamp the current decision.

module adaptive_transfer_tuner #(
  parameter int RATE_FRAC_BITS = att_pkg::RATE_FRAC_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           sample_valid,
  output logic                                sample_ready,
  input  wire att_pkg::sample_t               sample,
  output logic                                result_valid,
  input  wire logic                           result_ready,
  output att_pkg::result_t                    result,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [att_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [att_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [att_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready
);

  att_pkg::cfg_t     cfg;
  att_pkg::cmd_t     cmd;
  att_pkg::dp_stat_t stat;

  att_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  att_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  att_dp #(
    .RATE_FRAC_BITS (RATE_FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg          (cfg),
    .sample       (sample),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule

`default_nettype wire

// ----- dv/adaptive_transfer_tuner_tb.sv -----
// Self-checking testbench for the adaptive transfer tuner: APB setup, sample stimulus, result check.
`default_nettype none

module adaptive_transfer_tuner_tb;

  localparam int FRAC = att_pkg::RATE_FRAC_BITS_DEF;
  localparam logic [63:0] RATE_MAX = 64'hFFFF_FFFF_FFFF;
  localparam int RX_HOLD_CYCLES = 500;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic clk;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_ready;
  att_pkg::sample_t sample = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  att_pkg::result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [att_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [att_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [att_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  adaptive_transfer_tuner u_dut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample(sample),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  att_pkg::sample_t pending_samples[$];
  att_pkg::result_t expected_results[$];
  int queued_total = 0;
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_sender = 1'b0;
  logic hold_request = 1'b0;
  logic recv_block = 1'b0;

  // Tuner model: register copy and decision state
  att_pkg::cfg_t tune_cfg;
  logic [att_pkg::CHUNK_W-1:0] chunk_m;
  logic [att_pkg::DEPTH_W-1:0] depth_m;
  logic [att_pkg::RATE_W-1:0] rate_m;
  logic streak_m;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic model_restart();
    if (tune_cfg.start_chunk < tune_cfg.min_chunk) chunk_m = tune_cfg.min_chunk;
    else if (tune_cfg.start_chunk > tune_cfg.max_chunk) chunk_m = tune_cfg.max_chunk;
    else chunk_m = tune_cfg.start_chunk;
    if (tune_cfg.start_depth < tune_cfg.min_depth) depth_m = tune_cfg.min_depth;
    else if (tune_cfg.start_depth > tune_cfg.max_depth) depth_m = tune_cfg.max_depth;
    else depth_m = tune_cfg.start_depth;
    rate_m = '0;
    streak_m = 1'b0;
  endtask

  task automatic shrink_decision(input logic chunk_too);
    if ((depth_m >> 1) > tune_cfg.min_depth) depth_m = depth_m >> 1;
    else depth_m = tune_cfg.min_depth;
    if (chunk_too) begin
      if ((chunk_m >> 1) > tune_cfg.min_chunk) chunk_m = chunk_m >> 1;
      else chunk_m = tune_cfg.min_chunk;
    end
  endtask

  task automatic grow_depth_decision();
    logic [att_pkg::DEPTH_W-1:0] inc;
    inc = depth_m >> 2;
    if (inc == 0) inc = 1;
    if (depth_m >= tune_cfg.max_depth || inc > tune_cfg.max_depth - depth_m)
      depth_m = tune_cfg.max_depth;
    else
      depth_m = depth_m + inc;
  endtask

  // Works out the result word for one accepted sample and queues it
  task automatic predict_tuning(input att_pkg::sample_t s);
    logic [63:0] meas;
    logic [63:0] el;
    logic [63:0] avg;
    att_pkg::status_t st;
    att_pkg::result_t r;
    st = att_pkg::ST_OK;
    el = {16'd0, s.elapsed_ns};
    avg = {16'd0, rate_m};
    if (tune_cfg.min_chunk == 0 || tune_cfg.min_depth == 0 ||
        tune_cfg.min_chunk > tune_cfg.max_chunk || tune_cfg.min_depth > tune_cfg.max_depth) begin
      st = att_pkg::ST_BAD_BOUNDS;
    end else if (s.op == att_pkg::OP_RESTART) begin
      model_restart();
    end else if (s.bytes_done == 0 && !s.link_error) begin
      st = att_pkg::ST_EMPTY;
    end else if ((el == 0 || el[47]) && !s.link_error) begin
      st = att_pkg::ST_NONPOS;
    end else if (s.link_error) begin
      shrink_decision(1'b1);
      rate_m = '0;
      streak_m = 1'b0;
    end else begin
      meas = ({32'd0, s.bytes_done} << FRAC) / el;
      if (meas > RATE_MAX) meas = RATE_MAX;
      if (s.mem_pressure) begin
        shrink_decision(depth_m == tune_cfg.min_depth);
        rate_m = meas[47:0];
        streak_m = 1'b0;
      end else if (rate_m == 0) begin
        rate_m = meas[47:0];
      end else begin
        if (64'd100 * meas >= 64'd103 * avg) begin
          grow_depth_decision();
          if (streak_m) begin
            if (chunk_m >= tune_cfg.max_chunk || chunk_m > tune_cfg.max_chunk - chunk_m)
              chunk_m = tune_cfg.max_chunk;
            else
              chunk_m = chunk_m + chunk_m;
            streak_m = 1'b0;
          end else begin
            streak_m = 1'b1;
          end
        end else if (64'd40 * meas <= 64'd37 * avg) begin
          shrink_decision(1'b1);
          streak_m = 1'b0;
        end else if (s.starved) begin
          grow_depth_decision();
          streak_m = 1'b0;
        end else begin
          streak_m = 1'b0;
        end
        avg = (64'd3 * avg + meas) >> 2;
        rate_m = avg[47:0];
      end
    end
    r.status = st;
    r.chunk_out = chunk_m;
    r.depth_out = depth_m;
    expected_results.push_back(r);
  endtask

  // Sample driver: valid holds until the word is taken
  always @(posedge clk) begin : drive_samples
    logic busy;
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      busy = sample_valid;
      if (sample_valid && sample_ready) begin
        predict_tuning(sample);
        void'(pending_samples.pop_front());
        busy = 1'b0;
      end
      if (!busy) begin
        if (pending_samples.size() > 0 && !hold_sender &&
            $urandom_range(99) >= send_idle_pct) begin
          sample <= pending_samples[0];
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin : check_results
    att_pkg::result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", result);
        end else begin
          want = expected_results.pop_front();
          if (result.status !== want.status || result.chunk_out !== want.chunk_out ||
              result.depth_out !== want.depth_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: status exp %0d act %0d, chunk exp %0d act %0d,",
                       want.status, result.status, want.chunk_out, result.chunk_out,
                       " depth exp %0d act %0d", want.depth_out, result.depth_out);
          end
        end
      end
      result_ready <= !recv_block && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off so the block backs up onto its input
  initial begin : rx_holdoff
    wait (hold_request);
    @(posedge clk);
    recv_block <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    recv_block <= 1'b0;
  end

  initial begin : watchdog
    #10_000_000;
    $display("FAIL adaptive_transfer_tuner");
    $finish;
  end

  function automatic att_pkg::sample_t mk_sample(input logic op, input logic [31:0] b,
                                                 input logic [47:0] e, input logic err,
                                                 input logic mem, input logic st);
    att_pkg::sample_t s;
    s.op = op;
    s.bytes_done = b;
    s.elapsed_ns = e;
    s.link_error = err;
    s.mem_pressure = mem;
    s.starved = st;
    return s;
  endfunction

  task automatic offer(input att_pkg::sample_t s);
    pending_samples.push_back(s);
    queued_total++;
  endtask

  // APB write followed by a read-back of the same register
  task automatic cfg_write(input att_pkg::reg_idx_t idx, input logic [31:0] val);
    logic [31:0] kept;
    kept = val;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      att_pkg::REG_MIN_CHUNK:   tune_cfg.min_chunk = val;
      att_pkg::REG_MAX_CHUNK:   tune_cfg.max_chunk = val;
      att_pkg::REG_MIN_DEPTH: begin
        tune_cfg.min_depth = val[15:0];
        kept = {16'd0, val[15:0]};
      end
      att_pkg::REG_MAX_DEPTH: begin
        tune_cfg.max_depth = val[15:0];
        kept = {16'd0, val[15:0]};
      end
      att_pkg::REG_START_CHUNK: tune_cfg.start_chunk = val;
      att_pkg::REG_START_DEPTH: begin
        tune_cfg.start_depth = val[15:0];
        kept = {16'd0, val[15:0]};
      end
      default: ;
    endcase
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== kept) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register %0d read back: exp %h act %h", idx, kept, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_bounds(input logic [31:0] mnc, input logic [31:0] mxc,
                              input logic [15:0] mnd, input logic [15:0] mxd,
                              input logic [31:0] stc, input logic [15:0] st_dep);
    logic [31:0] junk;
    junk = $urandom;
    cfg_write(att_pkg::REG_MIN_CHUNK, mnc);
    cfg_write(att_pkg::REG_MAX_CHUNK, mxc);
    // upper half of a 16-bit register word is junk and must be dropped
    cfg_write(att_pkg::REG_MIN_DEPTH, {junk[31:16], mnd});
    cfg_write(att_pkg::REG_MAX_DEPTH, {junk[15:0], mxd});
    cfg_write(att_pkg::REG_START_CHUNK, stc);
    cfg_write(att_pkg::REG_START_DEPTH, {junk[23:8], st_dep});
  endtask

  task automatic set_idle(input idle_mode_t mode);
    @(posedge clk);
    case (mode)
      IDLE_NONE: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
      IDLE_SEND: begin send_idle_pct <= 84; recv_stall_pct <= 0;  end
      IDLE_RECV: begin send_idle_pct <= 0;  recv_stall_pct <= 84; end
      default:   begin send_idle_pct <= 31; recv_stall_pct <= 31; end
    endcase
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || sample_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // A run of plausible samples whose byte count moves by 88 to 114 percent per step
  task automatic push_run(input int len);
    logic [63:0] b;
    logic [63:0] e;
    logic [63:0] r;
    r = {$urandom, $urandom};
    b = {32'd0, $urandom} >> $urandom_range(0, 18);
    if (b == 0) b = 1;
    e = 64'($urandom_range(1, 65536)) << $urandom_range(0, 10);
    if ($urandom_range(1) == 1)
      offer(mk_sample(att_pkg::OP_RESTART, r[31:0], r[47:0], r[48], r[49], r[50]));
    for (int i = 0; i < len; i++) begin
      b = b * $urandom_range(88, 114) / 100;
      if (b == 0) b = 1;
      if (b > 64'hFFFF_FFFF) b = 64'hFFFF_FFFF;
      if ($urandom_range(7) == 0) e = e * $urandom_range(90, 110) / 100 + 1;
      offer(mk_sample(att_pkg::OP_OBSERVE, b[31:0], e[47:0], $urandom_range(39) == 0,
                      $urandom_range(29) == 0, $urandom_range(3) == 0));
    end
  endtask

  task automatic offer_noise();
    logic [63:0] r;
    logic [31:0] b;
    logic [47:0] e;
    r = {$urandom, $urandom};
    b = ($urandom_range(5) == 0) ? 32'd0 : $urandom;
    e = ($urandom_range(9) == 0) ? 48'd0 : r[47:0];
    offer(mk_sample($urandom_range(7) == 0, b, e, $urandom_range(1) == 1,
                    $urandom_range(1) == 1, $urandom_range(1) == 1));
  endtask

  initial begin : stimulus
    int n_items;
    int target;
    logic [31:0] mnc;
    logic [15:0] mnd;
    tune_cfg.min_chunk = att_pkg::MIN_CHUNK_RST;
    tune_cfg.max_chunk = att_pkg::MAX_CHUNK_RST;
    tune_cfg.min_depth = att_pkg::MIN_DEPTH_RST;
    tune_cfg.max_depth = att_pkg::MAX_DEPTH_RST;
    tune_cfg.start_chunk = att_pkg::START_CHUNK_RST;
    tune_cfg.start_depth = att_pkg::START_DEPTH_RST;
    model_restart();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    set_idle(IDLE_NONE);

    // Directed words at the reset configuration
    offer(mk_sample(att_pkg::OP_OBSERVE, 1000, 1000, 0, 0, 0));  // first estimate
    offer(mk_sample(att_pkg::OP_OBSERVE, 1000, 1000, 0, 0, 0));  // flat
    offer(mk_sample(att_pkg::OP_OBSERVE, 1000, 1000, 0, 0, 1));  // flat, starved
    offer(mk_sample(att_pkg::OP_OBSERVE, 1100, 1000, 0, 0, 0));  // gain
    offer(mk_sample(att_pkg::OP_OBSERVE, 1300, 1000, 0, 0, 0));  // second gain doubles chunk
    offer(mk_sample(att_pkg::OP_OBSERVE, 500, 1000, 0, 0, 0));   // drop
    offer(mk_sample(att_pkg::OP_OBSERVE, 1000, 1000, 0, 1, 0));  // memory pressure
    offer(mk_sample(att_pkg::OP_OBSERVE, 0, 0, 1, 0, 0));        // error wins over empty
    offer(mk_sample(att_pkg::OP_OBSERVE, 0, 1000, 0, 0, 0));     // empty
    offer(mk_sample(att_pkg::OP_OBSERVE, 1000, 0, 0, 0, 0));     // zero duration
    offer(mk_sample(att_pkg::OP_OBSERVE, 1000, 48'h8000_0000_0000, 0, 0, 0));
    offer(mk_sample(att_pkg::OP_OBSERVE, 1000, 48'hFFFF_FFFF_FFFF, 0, 0, 0));
    offer(mk_sample(att_pkg::OP_OBSERVE, 32'hFFFF_FFFF, 1, 0, 0, 0));  // largest rate
    offer(mk_sample(att_pkg::OP_OBSERVE, 32'hFFFF_FFFF, 48'h7FFF_FFFF_FFFF, 0, 0, 0));
    offer(mk_sample(att_pkg::OP_OBSERVE, 32'hFFFF_FFFF, 48'h7FFF_FFFF_FFFF, 1, 1, 1));
    offer(mk_sample(att_pkg::OP_OBSERVE, 1, 48'h7FFF_FFFF_FFFF, 0, 0, 0));  // truncates to zero
    offer(mk_sample(att_pkg::OP_OBSERVE, 1, 48'h7FFF_FFFF_FFFF, 0, 0, 1));
    offer(mk_sample(att_pkg::OP_OBSERVE, 1000, 1000, 0, 0, 0));
    offer(mk_sample(att_pkg::OP_RESTART, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1, 1, 1));
    offer(mk_sample(att_pkg::OP_RESTART, 0, 0, 0, 0, 0));
    offer(mk_sample(att_pkg::OP_OBSERVE, 32'hFFFF_FFFF, 1, 0, 1, 0));
    offer(mk_sample(att_pkg::OP_OBSERVE, 32'hFFFF_FFFF, 1, 0, 0, 1));
    wait_drained();

    for (int ph = 0; ph < 13; ph++) begin
      n_items = 140;
      case (ph)
        0: apply_bounds(att_pkg::MIN_CHUNK_RST, att_pkg::MAX_CHUNK_RST,
                        att_pkg::MIN_DEPTH_RST, att_pkg::MAX_DEPTH_RST,
                        att_pkg::START_CHUNK_RST, att_pkg::START_DEPTH_RST);
        1: apply_bounds(1, 32'hFFFF_FFFF, 1, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        2: begin
          // decision left over from the wide phase is not re-clamped
          apply_bounds(5000, 5000, 7, 7, 1, 16'hFFFF);
          n_items = 200;
        end
        3: apply_bounds(2048, 8192, 3, 12, 1, 1);
        5: begin apply_bounds(0, 8192, 1, 12, 4096, 4); n_items = 15; end
        6: begin apply_bounds(9000, 8999, 1, 12, 4096, 4); n_items = 15; end
        7: begin apply_bounds(4096, 8192, 0, 12, 4096, 4); n_items = 15; end
        8: begin apply_bounds(4096, 8192, 40, 39, 4096, 4); n_items = 15; end
        11: begin
          apply_bounds(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 0, 0);
          n_items = 100;
        end
        12: begin apply_bounds(1, 1, 1, 1, 32'hFFFF_FFFF, 16'hFFFF); n_items = 100; end
        default: begin
          mnc = $urandom_range(1, 65536);
          mnd = 16'($urandom_range(1, 16));
          apply_bounds(mnc, mnc + ($urandom >> $urandom_range(4, 31)), mnd,
                       16'(mnd + $urandom_range(0, 200)), $urandom >> $urandom_range(0, 31),
                       16'($urandom_range(0, 300)));
        end
      endcase

      if (ph == 2) set_idle(IDLE_NONE);
      else set_idle(idle_mode_t'(ph % 4));

      target = queued_total + n_items;
      while (queued_total < target) begin
        if ($urandom_range(9) < 8) push_run($urandom_range(4, 24));
        else offer_noise();
      end

      if (ph == 2) begin
        hold_request = 1'b1;
        while (pending_samples.size() > 100) @(posedge clk);
        // sender holds back until every queued result is out
        @(posedge clk);
        hold_sender <= 1'b1;
        @(posedge clk);
        while (sample_valid || expected_results.size() != 0) @(posedge clk);
        hold_sender <= 1'b0;
      end
      wait_drained();
    end

    repeat (64) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS adaptive_transfer_tuner");
    end else begin
      $display("FAIL adaptive_transfer_tuner");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/att_pkg.sv
rtl/att_regs.sv
rtl/att_ctrl.sv
rtl/att_dp.sv
rtl/adaptive_transfer_tuner.sv
dv/adaptive_transfer_tuner_tb.sv
